// File: hdl/wifisec_pkg.sv
// Shared types and constants for the beacon information element security classifier.
// No dependencies; imported by every module in hdl/.
package wifisec_pkg;

    localparam logic [7:0]  IE_RSN      = 8'd48;
    localparam logic [7:0]  IE_VENDOR   = 8'd221;
    localparam logic [7:0]  MIN_RSN_LEN = 8'd18;
    localparam logic [31:0] SAE_WINDOW  = 32'h000F_AC08;
    localparam logic [31:0] WPA1_PREFIX = 32'h0050_F201;
    localparam logic [7:0]  WIN_START   = 8'd3;

    localparam int FLG_RSN  = 0;
    localparam int FLG_WPA  = 1;
    localparam int FLG_WPA3 = 2;

    localparam int M_WEP  = 0;
    localparam int M_WPA  = 1;
    localparam int M_WPA2 = 2;
    localparam int M_WPA3 = 3;

    typedef enum logic [2:0] {
        PH_ID   = 3'b001,
        PH_LEN  = 3'b010,
        PH_DATA = 3'b100
    } phase_t;

    typedef enum logic [2:0] {
        CLS_OPEN     = 3'd0,
        CLS_WEP      = 3'd1,
        CLS_WPA      = 3'd2,
        CLS_WPA2     = 3'd3,
        CLS_AUTO     = 3'd4,
        CLS_UNLISTED = 3'd5
    } sec_class_t;

    typedef struct packed {
        logic       privacy_bit;
        logic       last_item;
        logic       first_item;
        logic       byte_present;
        logic [7:0] ie_byte;
    } ie_item_t;

    typedef struct packed {
        logic wpa3;
        logic wpa;
        logic rsn;
    } ie_flags_t;

endpackage

// File: hdl/wifisec_parser.sv
// Element walker: id / length / data state and the pending and committed security flags.
// Depends on wifisec_pkg.
module wifisec_parser import wifisec_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      step,
    input  ie_item_t  item,
    output ie_flags_t flags_out
);

    phase_t      phase_reg, phase_next, phase_b;
    logic [7:0]  id_reg, id_next, id_b;
    logic [7:0]  len_reg, len_next, len_b;
    logic [7:0]  ofs_reg, ofs_next, ofs_b;
    logic [23:0] recent_reg, recent_next, recent_b;
    logic [2:0]  pend_reg, pend_next, pend_b;
    logic [2:0]  comm_reg, comm_next, comm_b;
    logic [31:0] win;
    logic [7:0]  ofs_inc;

    always_comb begin
        phase_b  = item.first_item ? PH_ID : phase_reg;
        id_b     = item.first_item ? 8'd0  : id_reg;
        len_b    = item.first_item ? 8'd0  : len_reg;
        ofs_b    = item.first_item ? 8'd0  : ofs_reg;
        recent_b = item.first_item ? 24'd0 : recent_reg;
        pend_b   = item.first_item ? 3'd0  : pend_reg;
        comm_b   = item.first_item ? 3'd0  : comm_reg;

        win     = {recent_b, item.ie_byte};
        ofs_inc = ofs_b + 8'd1;

        phase_next  = phase_b;
        id_next     = id_b;
        len_next    = len_b;
        ofs_next    = ofs_b;
        recent_next = recent_b;
        pend_next   = pend_b;
        comm_next   = comm_b;

        if (item.byte_present) begin
            unique case (phase_b)
                PH_LEN: begin
                    len_next    = item.ie_byte;
                    ofs_next    = 8'd0;
                    recent_next = 24'd0;
                    pend_next   = {2'b00, id_b == IE_RSN};
                    if (item.ie_byte == 8'd0) begin
                        comm_next  = comm_b | pend_next;
                        pend_next  = 3'd0;
                        phase_next = PH_ID;
                    end else begin
                        phase_next = PH_DATA;
                    end
                end
                PH_DATA: begin
                    if (ofs_b >= WIN_START) begin
                        if (id_b == IE_RSN && len_b >= MIN_RSN_LEN && win == SAE_WINDOW)
                            pend_next[FLG_WPA3] = 1'b1;
                        if (ofs_b == WIN_START && id_b == IE_VENDOR && win == WPA1_PREFIX)
                            pend_next[FLG_WPA] = 1'b1;
                    end
                    recent_next = win[23:0];
                    ofs_next    = ofs_inc;
                    if (ofs_inc == len_b) begin
                        comm_next  = comm_b | pend_next;
                        pend_next  = 3'd0;
                        phase_next = PH_ID;
                    end
                end
                default: begin
                    id_next    = item.ie_byte;
                    phase_next = PH_LEN;
                end
            endcase
        end

        flags_out.rsn  = comm_next[FLG_RSN];
        flags_out.wpa  = comm_next[FLG_WPA];
        flags_out.wpa3 = comm_next[FLG_WPA3];

        if (item.last_item) begin
            phase_next  = PH_ID;
            id_next     = 8'd0;
            len_next    = 8'd0;
            ofs_next    = 8'd0;
            recent_next = 24'd0;
            pend_next   = 3'd0;
            comm_next   = 3'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_ID;
            id_reg     <= 8'd0;
            len_reg    <= 8'd0;
            ofs_reg    <= 8'd0;
            recent_reg <= 24'd0;
            pend_reg   <= 3'd0;
            comm_reg   <= 3'd0;
        end else if (step) begin
            phase_reg  <= phase_next;
            id_reg     <= id_next;
            len_reg    <= len_next;
            ofs_reg    <= ofs_next;
            recent_reg <= recent_next;
            pend_reg   <= pend_next;
            comm_reg   <= comm_next;
        end
    end

endmodule

// File: hdl/wifisec_classify.sv
// Security mask and class code from the committed flags, held in the result register.
// Depends on wifisec_pkg.
module wifisec_classify import wifisec_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        load,
    input  logic        privacy_bit,
    input  ie_flags_t   flags,
    output logic        out_free,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata     // auth_mask[3:0], security_class[6:4], rsn_found[7],
                                    // wpa_found[8], zero [15:9]
);

    logic        m_tvalid_reg, m_tvalid_next;
    logic [8:0]  res_reg, res_next;
    logic [3:0]  mask;
    sec_class_t  cls;

    always_comb begin
        mask = 4'd0;
        mask[M_WPA3] = flags.wpa3;
        if (privacy_bit) begin
            mask[M_WEP]  = !flags.rsn && !flags.wpa;
            mask[M_WPA]  = flags.wpa;
            mask[M_WPA2] = flags.rsn && !flags.wpa3;
        end
        unique case (mask)
            4'b0000: cls = CLS_OPEN;
            4'b0001: cls = CLS_WEP;
            4'b0010: cls = CLS_WPA;
            4'b0100: cls = CLS_WPA2;
            4'b0110: cls = CLS_AUTO;
            4'b1000: cls = CLS_AUTO;
            default: cls = CLS_UNLISTED;
        endcase
    end

    assign out_free      = !m_tvalid_reg || m_tready;
    assign m_tvalid_next = load || (m_tvalid_reg && !m_tready);
    assign res_next      = {flags.wpa, flags.rsn, cls, mask};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, res_reg};

endmodule

// File: hdl/wifi_ie_security_classifier_unit.sv
// Top level of the beacon information element security classifier: input register,
// element walker and result register. Depends on wifisec_pkg, wifisec_parser, wifisec_classify.
//
// Takes one information element area byte per beat and walks its id / length / data
// records; the beat with tlast set yields one result beat with the security mask, class
// code and RSN / WPA flags. One beat is accepted every cycle unless a tlast beat waits in the
// input register for the result register to be taken. A beat is parsed against the element
// state while it sits in the input register, and a tlast beat's result is loaded into the
// result register when that beat steps, after which m_tvalid is raised. The result register
// stalls only tlast beats; other beats keep flowing while a result waits.
module wifi_ie_security_classifier_unit import wifisec_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // ie_byte[7:0], privacy_bit[8], zero [15:9]
    input  logic        s_tlast,    // last_item
    input  logic [1:0]  s_tuser,    // byte_present[0], first_item[1]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata     // auth_mask[3:0], security_class[6:4], rsn_found[7],
                                    // wpa_found[8], zero [15:9]
);

    logic      in_valid_reg, in_valid_next;
    ie_item_t  in_item_reg, in_item_next;
    logic      out_free;
    logic      step;
    ie_flags_t flags;

    assign step     = in_valid_reg && (!in_item_reg.last_item || out_free);
    assign s_tready = !in_valid_reg || step;

    assign in_valid_next = s_tvalid || (in_valid_reg && !step);

    always_comb begin
        in_item_next.ie_byte      = s_tdata[7:0];
        in_item_next.privacy_bit  = s_tdata[8];
        in_item_next.last_item    = s_tlast;
        in_item_next.byte_present = s_tuser[0];
        in_item_next.first_item   = s_tuser[1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg <= in_item_next;
        end
    end

    wifisec_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .item      (in_item_reg),
        .flags_out (flags)
    );

    wifisec_classify u_classify (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load        (step && in_item_reg.last_item),
        .privacy_bit (in_item_reg.privacy_bit),
        .flags       (flags),
        .out_free    (out_free),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule

// File: tb/sv/tb_wifi_ie_security_classifier_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for wifi_ie_security_classifier_unit: streams beacon IE areas
// and checks each classification beat against an in-bench element walker.
// Depends on wifisec_pkg and the hdl/ sources of the unit.
module tb_wifi_ie_security_classifier_unit;
    import wifisec_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 80;
    localparam int TOTAL_BEATS    = 900;

    localparam logic [3:0] MASK_OPEN = 4'd0;
    localparam logic [3:0] MASK_WEP  = 4'(1 << M_WEP);
    localparam logic [3:0] MASK_WPA  = 4'(1 << M_WPA);
    localparam logic [3:0] MASK_WPA2 = 4'(1 << M_WPA2);
    localparam logic [3:0] MASK_WPA3 = 4'(1 << M_WPA3);

    typedef logic [7:0] byte_queue_t [$];

    typedef struct {
        logic [3:0] mask;
        sec_class_t cls;
        logic       rsn;
        logic       wpa;
    } sec_verdict_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;
    logic        s_tlast  = 1'b0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;

    bit gaps_off  = 1'b0;
    int hold_tag  = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int quiet_cycles = 0;

    int mismatch_count   = 0;
    int beats_sent       = 0;
    int areas_sent       = 0;
    int verdicts_checked = 0;

    sec_verdict_t expected_verdicts[$];

    // element walker state
    phase_t     walk_phase;
    logic [7:0] walk_id;
    logic [7:0] walk_len;
    logic [7:0] walk_off;
    logic [23:0] walk_recent;
    ie_flags_t  open_flags;
    ie_flags_t  done_flags;

    wifi_ie_security_classifier_unit DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic void clear_walk();
        walk_phase  = PH_ID;
        walk_id     = '0;
        walk_len    = '0;
        walk_off    = '0;
        walk_recent = '0;
        open_flags  = '0;
        done_flags  = '0;
    endfunction

    function automatic void close_element();
        done_flags = done_flags | open_flags;
        open_flags = '0;
        walk_phase = PH_ID;
    endfunction

    function automatic void take_ie_byte(logic [7:0] b);
        logic [31:0] win;
        case (walk_phase)
            PH_LEN: begin
                walk_len    = b;
                walk_off    = '0;
                walk_recent = '0;
                open_flags  = '0;
                open_flags.rsn = (walk_id == IE_RSN);
                if (b == 8'd0) close_element();
                else walk_phase = PH_DATA;
            end
            PH_DATA: begin
                win = {walk_recent, b};
                if (walk_off >= WIN_START) begin
                    if (walk_id == IE_RSN && walk_len >= MIN_RSN_LEN && win == SAE_WINDOW)
                        open_flags.wpa3 = 1'b1;
                    if (walk_off == WIN_START && walk_id == IE_VENDOR && win == WPA1_PREFIX)
                        open_flags.wpa = 1'b1;
                end
                walk_recent = win[23:0];
                walk_off    = walk_off + 8'd1;
                if (walk_off == walk_len) close_element();
            end
            default: begin
                walk_id    = b;
                walk_phase = PH_LEN;
            end
        endcase
    endfunction

    function automatic void walk_ie_beat(ie_item_t it);
        sec_verdict_t v;
        logic [3:0]   mask;
        if (it.first_item) clear_walk();
        if (it.byte_present) take_ie_byte(it.ie_byte);
        if (!it.last_item) return;
        mask = MASK_OPEN;
        if (done_flags.wpa3) mask = mask | MASK_WPA3;
        if (it.privacy_bit) begin
            if (!done_flags.rsn && !done_flags.wpa) mask = mask | MASK_WEP;
            if (done_flags.wpa) mask = mask | MASK_WPA;
            if (done_flags.rsn && !mask[M_WPA3]) mask = mask | MASK_WPA2;
        end
        case (mask)
            MASK_OPEN:            v.cls = CLS_OPEN;
            MASK_WEP:             v.cls = CLS_WEP;
            MASK_WPA:             v.cls = CLS_WPA;
            MASK_WPA2:            v.cls = CLS_WPA2;
            MASK_WPA | MASK_WPA2: v.cls = CLS_AUTO;
            MASK_WPA3:            v.cls = CLS_AUTO;
            default:              v.cls = CLS_UNLISTED;
        endcase
        v.mask = mask;
        v.rsn  = done_flags.rsn;
        v.wpa  = done_flags.wpa;
        expected_verdicts.push_back(v);
        clear_walk();
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("tb: mismatch at %0t ns: %s", $time, msg);
    endtask

    task automatic check_verdict(input logic [15:0] word);
        sec_verdict_t want;
        if (expected_verdicts.size() == 0) begin
            report_mismatch($sformatf("result beat %h with no area pending", word));
            return;
        end
        want = expected_verdicts.pop_front();
        verdicts_checked++;
        if (word[3:0] !== want.mask)
            report_mismatch($sformatf("auth_mask %h, want %h", word[3:0], want.mask));
        if (word[6:4] !== want.cls)
            report_mismatch($sformatf("security_class %0d, want %0d", word[6:4], want.cls));
        if (word[7] !== want.rsn)
            report_mismatch($sformatf("rsn_found %b, want %b", word[7], want.rsn));
        if (word[8] !== want.wpa)
            report_mismatch($sformatf("wpa_found %b, want %b", word[8], want.wpa));
    endtask

    // result side: check, then decide tready (long hold on request)
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) check_verdict(m_tdata);
        if (hold_tag != hold_seen) begin
            hold_seen <= hold_tag;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= gaps_off || ($urandom_range(99) >= 25);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("tb: no beat moved for %0d cycles", WATCHDOG_LIMIT);
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_beat(input ie_item_t it);
        while (!gaps_off && $urandom_range(99) < 25) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, it.privacy_bit, it.ie_byte};
        s_tlast  <= it.last_item;
        s_tuser  <= {it.first_item, it.byte_present};
        do @(posedge aclk); while (!s_tready);
        walk_ie_beat(it);
        beats_sent++;
    endtask

    // noisy areas get idle beats, stray first_item and at times a separate closing beat
    task automatic send_area(input byte_queue_t area, input logic privacy, input bit noisy);
        ie_item_t it;
        bit       split_last;
        split_last = (area.size() == 0) || (noisy && $urandom_range(4) == 0);
        foreach (area[i]) begin
            if (noisy && $urandom_range(14) == 0) begin
                it.ie_byte      = 8'($urandom);
                it.byte_present = 1'b0;
                it.first_item   = ($urandom_range(29) == 0);
                it.last_item    = 1'b0;
                it.privacy_bit  = 1'($urandom_range(1));
                send_beat(it);
            end
            it.ie_byte      = area[i];
            it.byte_present = 1'b1;
            if (noisy) it.first_item = (i == 0) ? 1'($urandom_range(1))
                                                : ($urandom_range(99) == 0);
            else it.first_item = (i == 0);
            it.last_item    = !split_last && (i == area.size() - 1);
            it.privacy_bit  = (it.last_item || !noisy) ? privacy : 1'($urandom_range(1));
            send_beat(it);
        end
        if (split_last) begin
            it.ie_byte      = noisy ? 8'($urandom) : 8'hFF;
            it.byte_present = 1'b0;
            it.first_item   = (area.size() == 0) && (noisy ? $urandom_range(1) : 1'b1);
            it.last_item    = 1'b1;
            it.privacy_bit  = privacy;
            send_beat(it);
        end
        areas_sent++;
    endtask

    task automatic add_element(ref byte_queue_t area);
        int          kind;
        int          len;
        int          pos;
        int          base;
        int          flip;
        logic [7:0]  id;
        logic [31:0] pat;
        kind = $urandom_range(9);
        pat  = SAE_WINDOW;
        case (kind)
            0, 1, 2: begin
                id  = IE_RSN;
                len = $urandom_range(1) ? $urandom_range(40, 18) : $urandom_range(17);
            end
            3, 4: begin
                id  = IE_VENDOR;
                len = $urandom_range(12);
                pat = WPA1_PREFIX;
            end
            5: begin
                id  = 8'($urandom_range(255));
                len = $urandom_range(24, 4);
            end
            default: begin
                id  = 8'($urandom_range(255));
                len = ($urandom_range(59) == 0) ? $urandom_range(255) : $urandom_range(10);
            end
        endcase
        area.push_back(id);
        area.push_back(8'(len));
        base = area.size();
        repeat (len) area.push_back(8'($urandom));
        if (len >= 4 && $urandom_range(9) < 7) begin
            if (kind == 3 || kind == 4) pos = ($urandom_range(4) == 0) ? 1 : 0;
            else pos = ($urandom_range(2) == 0) ? len - 4 : $urandom_range(len - 4);
            if ($urandom_range(7) == 0) begin
                flip = $urandom_range(31);
                pat[flip] = ~pat[flip];
            end
            for (int k = 0; k < 4; k++) area[base + pos + k] = pat[31 - 8 * k -: 8];
        end
    endtask

    task automatic build_area(output byte_queue_t area);
        int keep;
        area = {};
        if ($urandom_range(11) == 0) begin
            repeat ($urandom_range(20, 1)) area.push_back(8'($urandom));
        end else begin
            repeat ($urandom_range(4)) add_element(area);
        end
        if (area.size() > 0 && $urandom_range(6) == 0) begin
            keep = $urandom_range(area.size() - 1);
            while (area.size() > keep) void'(area.pop_back());
        end
    endtask

    task automatic test_special_cases();
        byte_queue_t area;
        area = {};
        send_area(area, 1'b1, 1'b0);
        send_area(area, 1'b0, 1'b0);
        // lone id byte: cut off, nothing committed
        area = {IE_RSN};
        send_area(area, 1'b1, 1'b0);
        // zero-length RSN followed by a WPA vendor element
        area = {IE_RSN, 8'd0, IE_VENDOR, 8'd4, 8'h00, 8'h50, 8'hF2, 8'h01};
        send_area(area, 1'b1, 1'b0);
        // SAE suite in the final window of an 18-byte RSN, privacy clear
        area = {IE_RSN, MIN_RSN_LEN};
        repeat (14) area.push_back(8'h01);
        area = {area, 8'h00, 8'h0F, 8'hAC, 8'h08};
        send_area(area, 1'b0, 1'b0);
    endtask

    task automatic test_backpressure();
        byte_queue_t area;
        hold_tag <= hold_tag + 1;
        gaps_off <= 1'b1;
        repeat (8) begin
            area = {8'($urandom_range(255)), 8'd0};
            send_area(area, 1'($urandom_range(1)), 1'b0);
        end
        gaps_off <= 1'b0;
    endtask

    task automatic test_streaming();
        byte_queue_t area;
        gaps_off <= 1'b1;
        repeat (15) begin
            build_area(area);
            send_area(area, 1'($urandom_range(1)), 1'b1);
        end
        gaps_off <= 1'b0;
    endtask

    task automatic test_random_areas();
        byte_queue_t area;
        while (beats_sent < TOTAL_BEATS) begin
            build_area(area);
            send_area(area, 1'($urandom_range(1)), 1'b1);
        end
    endtask

    initial begin
        clear_walk();
        aresetn <= 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        test_special_cases();
        test_backpressure();
        test_streaming();
        test_random_areas();
        s_tvalid <= 1'b0;
        while (expected_verdicts.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        $display("tb: %0d beats in %0d IE areas, %0d classifications checked, %0d mismatches",
                 beats_sent, areas_sent, verdicts_checked, mismatch_count);
        $display("tb: covered cut-off, zero-length, WPA/WPA3 elements, a %0d-cycle result stall",
                 HOLD_CYCLES);
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
